/* rtl/core/m4m_pkg.sv */
`timescale 1ns / 1ps

package m4m_pkg;

    // Fixed-point format and matrix shape
    localparam int FRAC_BITS = 16;
    localparam int DIM       = 4;
    localparam int WORD_W    = 32;
    localparam int PROD_W    = 2 * WORD_W;
    // Four 64-bit products plus rounding need 66 bits
    localparam int ACC_W     = PROD_W + 2;

    // Rounding offset: half an LSB of the result, zero when there is no fraction
    localparam logic signed [ACC_W-1:0] RND_ACC = (ACC_W'(1) << FRAC_BITS) >> 1;
    // Saturation bounds of the 32-bit result, sign-extended to accumulator width
    localparam logic signed [ACC_W-1:0] MAX_ACC = {{(ACC_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] MIN_ACC = {{(ACC_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};

    typedef logic [WORD_W-1:0]          t_word;
    typedef t_word [DIM-1:0]            t_row;
    typedef logic [$clog2(DIM)-1:0]     t_idx;

    // Per-lane pipeline controls issued by the sequencer
    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic first;
    } t_lane_ctl;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_DRAIN = 3'b100
    } t_state;

endpackage

/* rtl/core/m4m_row_mem.sv */
`timescale 1ns / 1ps

module m4m_row_mem (
    input  logic          i_clk,
    input  logic          i_we,
    input  m4m_pkg::t_idx i_waddr,
    input  m4m_pkg::t_row i_wdata,
    input  m4m_pkg::t_idx i_raddr,
    output m4m_pkg::t_row o_rdata
);
    import m4m_pkg::*;

    t_row r_mem [DIM];
    t_row r_rdata;

    // Write one matrix row per transfer
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/m4m_lane.sv */
`timescale 1ns / 1ps

module m4m_lane (
    input  logic               i_clk,
    input  m4m_pkg::t_lane_ctl i_ctl,
    input  m4m_pkg::t_word     i_a,
    input  m4m_pkg::t_word     i_b,
    output m4m_pkg::t_word     o_value,
    output logic               o_sat
);
    import m4m_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  acc_base;
    logic signed [ACC_W-1:0]  quot;
    logic                     sat_hi;
    logic                     sat_lo;

    // Multiply one left element by one right element
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= $signed(i_a) * $signed(i_b);
        end
    end

    // Accumulate; the first term starts from the rounding offset
    always_comb begin
        acc_base = i_ctl.first ? RND_ACC : r_acc;
        n_acc    = acc_base + ACC_W'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.acc_en) begin
            r_acc <= n_acc;
        end
    end

    // Drop fraction bits and clamp to 32 bits
    always_comb begin
        quot   = r_acc >>> FRAC_BITS;
        sat_hi = quot > MAX_ACC;
        sat_lo = quot < MIN_ACC;
        o_sat  = sat_hi | sat_lo;
        if (sat_hi) begin
            o_value = MAX_ACC[WORD_W-1:0];
        end else if (sat_lo) begin
            o_value = MIN_ACC[WORD_W-1:0];
        end else begin
            o_value = quot[WORD_W-1:0];
        end
    end

endmodule

/* rtl/core/matrix4x4_multiply.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// row in    input      start && !busy        i_left_e0..3, i_right_e0..3
// row out   output     o_strobe (one cycle)  o_out_row, o_prod_e0..3, o_clipped, o_final_row
//
// Rows 0 to 2 are accepted while busy stays low.
// Row 3 starts the product: busy rises and stays high through the 16 read steps of the
// row memories (one left row and one right row per step) and the multiply/accumulate pipe.
// Product rows transfer in order, 0 to 3, after the row 3 transfer; no rows are taken while busy.
// Synchronous active-low reset clears the row count, sequencer and strobe; stores are not cleared.
// The receiver cannot stall: each product row is shown for exactly one cycle.

module matrix4x4_multiply (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [31:0]  i_left_e0,
    input  logic signed [31:0]  i_left_e1,
    input  logic signed [31:0]  i_left_e2,
    input  logic signed [31:0]  i_left_e3,
    input  logic signed [31:0]  i_right_e0,
    input  logic signed [31:0]  i_right_e1,
    input  logic signed [31:0]  i_right_e2,
    input  logic signed [31:0]  i_right_e3,
    output logic                o_strobe,
    output logic [1:0]          o_out_row,
    output logic signed [31:0]  o_prod_e0,
    output logic signed [31:0]  o_prod_e1,
    output logic signed [31:0]  o_prod_e2,
    output logic signed [31:0]  o_prod_e3,
    output logic                o_clipped,
    output logic                o_final_row
);
    import m4m_pkg::*;

    localparam t_idx LAST_IDX = t_idx'(DIM - 1);

    t_state    r_state;
    t_state    n_state;
    t_idx      r_row_count;
    t_idx      r_step_i;
    t_idx      r_step_k;
    logic      accept;
    logic      issue;
    t_row      left_row;
    t_row      right_row;
    t_row      left_rdata;
    t_row      right_rdata;

    logic      r_v1;
    t_idx      r_i1;
    t_idx      r_k1;
    logic      r_v2;
    t_idx      r_i2;
    t_idx      r_k2;
    logic      r_v3;
    t_idx      r_i3;

    logic      r_strobe;
    t_idx      r_out_row;
    t_word     r_prod_e0;
    t_word     r_prod_e1;
    t_word     r_prod_e2;
    t_word     r_prod_e3;
    logic      r_clipped;
    logic      r_final_row;

    t_lane_ctl lane_ctl;
    t_word     lane_value [DIM];
    logic      lane_sat   [DIM];

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign issue  = (r_state == ST_ISSUE);

    assign left_row  = {i_left_e3, i_left_e2, i_left_e1, i_left_e0};
    assign right_row = {i_right_e3, i_right_e2, i_right_e1, i_right_e0};

    // Store both rows; read left row i and right row k per step
    m4m_row_mem u_left_mem (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_row_count),
        .i_wdata (left_row),
        .i_raddr (r_step_i),
        .o_rdata (left_rdata)
    );

    m4m_row_mem u_right_mem (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_row_count),
        .i_wdata (right_row),
        .i_raddr (r_step_k),
        .o_rdata (right_rdata)
    );

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && r_row_count == LAST_IDX) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (r_step_i == LAST_IDX && r_step_k == LAST_IDX) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_v3 && r_i3 == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Advance row count, state and read step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_row_count <= '0;
            r_step_i    <= '0;
            r_step_k    <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_row_count <= r_row_count + 1'b1;
            end
            if (issue) begin
                {r_step_i, r_step_k} <= {r_step_i, r_step_k} + 1'b1;
            end
        end
    end

    // Pipeline valids: read data, product, finished sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_v1     <= issue;
            r_v2     <= r_v1;
            r_v3     <= r_v2 && r_k2 == LAST_IDX;
            r_strobe <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i1 <= r_step_i;
        r_k1 <= r_step_k;
        r_i2 <= r_i1;
        r_k2 <= r_k1;
        r_i3 <= r_i2;
    end

    assign lane_ctl.mul_en = r_v1;
    assign lane_ctl.acc_en = r_v2;
    assign lane_ctl.first  = (r_k2 == '0);

    // One lane per product column: P[i][j] += A[i][k] * B[k][j]
    for (genvar j = 0; j < DIM; j++) begin : g_lane
        m4m_lane u_lane (
            .i_clk   (i_clk),
            .i_ctl   (lane_ctl),
            .i_a     (left_rdata[r_k1]),
            .i_b     (right_rdata[j]),
            .o_value (lane_value[j]),
            .o_sat   (lane_sat[j])
        );
    end

    // Hold the finished product row for its single strobe cycle
    always_ff @(posedge i_clk) begin
        if (r_v3) begin
            r_out_row   <= r_i3;
            r_prod_e0   <= lane_value[0];
            r_prod_e1   <= lane_value[1];
            r_prod_e2   <= lane_value[2];
            r_prod_e3   <= lane_value[3];
            r_clipped   <= lane_sat[0] | lane_sat[1] | lane_sat[2] | lane_sat[3];
            r_final_row <= (r_i3 == LAST_IDX);
        end
    end

    assign o_strobe    = r_strobe;
    assign o_out_row   = r_out_row;
    assign o_prod_e0   = r_prod_e0;
    assign o_prod_e1   = r_prod_e1;
    assign o_prod_e2   = r_prod_e2;
    assign o_prod_e3   = r_prod_e3;
    assign o_clipped   = r_clipped;
    assign o_final_row = r_final_row;

`ifndef ASSERT_OFF
    a_busy_after_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_row_count == LAST_IDX) |=> busy)
        else $error("busy not raised after the last row transfer");

    a_row_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_final_row) |-> ##4 (o_strobe && o_out_row == $past(o_out_row, 4) + 2'd1))
        else $error("product rows not four cycles apart in order");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("strobe held for more than one cycle");

    a_final_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_final_row) |-> !busy)
        else $error("still busy on the last product row");
`endif

endmodule
